// File: src/fda_pkg.sv
`timescale 1ns / 1ps

package fda_pkg;

	typedef enum logic [1:0] {
		OP_ARM   = 2'd0,
		OP_ACCEL = 2'd1,
		OP_ALT   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_LOW_G   = 2'd1,
		CAUSE_DESCENT = 2'd2
	} cause_t;

	typedef enum logic [1:0] {
		CFG_LOW_G_THR_SQ = 2'd0,
		CFG_LOW_G_HOLD   = 2'd1,
		CFG_DESCENT_THR  = 2'd2,
		CFG_DESCENT_WIN  = 2'd3
	} cfg_idx_t;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [31:0] RST_LOW_G_THR_SQ = 32'd67108864;
	localparam logic [15:0] RST_LOW_G_HOLD   = 16'd1000;
	localparam logic [16:0] RST_DESCENT_THR  = 17'd1000;
	localparam logic [15:0] RST_DESCENT_WIN  = 16'd1000;

	// arm stamps ring entries this far in the past so none is timely
	localparam logic [31:0] STALE_OFFSET = 32'h8000_0000;
	localparam logic signed [32:0] DROP_SAT = 33'sh0_7FFF_FFFF;

endpackage

// File: src/fda_req_if.sv
`timescale 1ns / 1ps

interface fda_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [31:0]        now_ms;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [31:0] altitude_cm;

	modport source (
		output valid, operation, now_ms, accel_x, accel_y, accel_z, altitude_cm,
		input  ready
	);
	modport sink (
		input  valid, operation, now_ms, accel_x, accel_y, accel_z, altitude_cm,
		output ready
	);
endinterface

// File: src/fda_rsp_if.sv
`timescale 1ns / 1ps

interface fda_rsp_if;
	logic               valid;
	logic               ready;
	logic               alarm;
	logic [1:0]         alarm_cause;
	logic               low_g_active;
	logic               is_armed;
	logic signed [31:0] drop_cm;

	modport source (
		output valid, alarm, alarm_cause, low_g_active, is_armed, drop_cm,
		input  ready
	);
	modport sink (
		input  valid, alarm, alarm_cause, low_g_active, is_armed, drop_cm,
		output ready
	);
endinterface

// File: src/freefall_descent_alarm.sv
`timescale 1ns / 1ps

// channel | dir | handshake     | payload
// req     | in  | valid / ready | operation, now_ms, accel_x/y/z, altitude_cm
// rsp     | out | valid / ready | alarm, alarm_cause, low_g_active, is_armed, drop_cm
// cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// One request at a time. Altitude: a walk through the ring memory, one read per
// cycle. Arm: one ring write per cycle. Accelerometer: through one shared
// squarer. Other requests go straight to the emit state. Reset clears the control
// state; the ring is written by arm before it is read. A stalled rsp holds its
// result while the next request is taken and worked on; that one then waits to
// be emitted.

module freefall_descent_alarm #(
	parameter int RING_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fda_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fda_pkg::CFG_DATA_W-1:0]   cfg_data,
	fda_req_if.sink                          req,
	fda_rsp_if.source                        rsp
);

	localparam int ADDR_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0]  WALK_END  = CNT_W'(RING_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ARM,
		S_SQ,
		S_SUM,
		S_WALK,
		S_EMIT
	} state_t;

	// configuration
	logic [31:0] low_g_thr_sq_q;
	logic [15:0] low_g_hold_q;
	logic [16:0] descent_thr_q;
	logic [15:0] descent_win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_g_thr_sq_q <= fda_pkg::RST_LOW_G_THR_SQ;
			low_g_hold_q   <= fda_pkg::RST_LOW_G_HOLD;
			descent_thr_q  <= fda_pkg::RST_DESCENT_THR;
			descent_win_q  <= fda_pkg::RST_DESCENT_WIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fda_pkg::CFG_LOW_G_THR_SQ: low_g_thr_sq_q <= cfg_data;
				fda_pkg::CFG_LOW_G_HOLD:   low_g_hold_q   <= cfg_data[15:0];
				fda_pkg::CFG_DESCENT_THR:  descent_thr_q  <= cfg_data[16:0];
				fda_pkg::CFG_DESCENT_WIN:  descent_win_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// state
	state_t              state_q;
	logic                armed_q;
	logic                alarm_q;
	logic [1:0]          cause_q;
	logic                low_g_seen_q;
	logic [31:0]         low_g_start_q;
	logic [ADDR_W-1:0]   slot_q;
	logic signed [31:0]  drop_q;

	// request payload and working registers
	logic [31:0]         now_q;
	logic signed [31:0]  alt_q;
	logic signed [15:0]  ax_q, ay_q, az_q;
	logic [1:0]          sq_idx_q;
	logic [31:0]         prod_s1;
	logic [31:0]         acc_q;
	logic [ADDR_W-1:0]   arm_idx_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic [CNT_W-1:0]    issue_k_q;
	logic                rd_pend_s1;
	logic signed [32:0]  best_q;

	// result register
	logic                rsp_valid_q;
	logic                rsp_alarm_q;
	logic [1:0]          rsp_cause_q;
	logic                rsp_low_g_q;
	logic                rsp_armed_q;
	logic signed [31:0]  rsp_drop_q;

	// ring memory: {stamp, altitude}
	logic [63:0]       ring_mem [RING_DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [63:0]       mem_wdata;
	logic [63:0]       mem_rdata_s1;

	logic accept;
	logic active;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign active    = armed_q && !alarm_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = {req.now_ms, req.altitude_cm};
		if (state_q == S_ARM) begin
			mem_we    = 1'b1;
			mem_waddr = arm_idx_q;
			mem_wdata = {now_q - fda_pkg::STALE_OFFSET, alt_q};
		end else if (accept && req.operation == fda_pkg::OP_ALT && active) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_s1 <= ring_mem[rd_addr_q];
	end

	// squaring, one axis per cycle
	logic signed [15:0] sq_operand;
	logic signed [31:0] sq_prod;
	logic [31:0]        mag_sq;
	logic [31:0]        low_g_age;

	always_comb begin
		unique case (sq_idx_q)
			2'd0:    sq_operand = ax_q;
			2'd1:    sq_operand = ay_q;
			default: sq_operand = az_q;
		endcase
	end

	assign sq_prod   = sq_operand * sq_operand;
	assign mag_sq    = acc_q + prod_s1;
	assign low_g_age = now_q - low_g_start_q;

	// walk evaluation of the entry read in the previous cycle
	logic [31:0]        entry_age;
	logic               timely;
	logic signed [32:0] drop;
	logic               hit;
	logic signed [32:0] best_n;
	logic               stop;
	logic               walk_done;
	logic [31:0]        drop_sat;

	assign entry_age = now_q - mem_rdata_s1[63:32];
	assign timely    = entry_age < {16'b0, descent_win_q};
	assign drop      = {mem_rdata_s1[31], mem_rdata_s1[31:0]} - {alt_q[31], alt_q};
	assign hit       = rd_pend_s1 && timely && (drop >= $signed({16'b0, descent_thr_q}));
	assign best_n    = (rd_pend_s1 && timely && drop > best_q) ? drop : best_q;
	assign stop      = rd_pend_s1 && (!timely || hit);
	assign walk_done = stop || (rd_pend_s1 && issue_k_q == WALK_END);
	assign drop_sat  = (best_n > fda_pkg::DROP_SAT) ? fda_pkg::DROP_SAT[31:0] : best_n[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			armed_q       <= 1'b0;
			alarm_q       <= 1'b0;
			cause_q       <= fda_pkg::CAUSE_NONE;
			low_g_seen_q  <= 1'b0;
			low_g_start_q <= '0;
			slot_q        <= '0;
			drop_q        <= '0;
			now_q         <= '0;
			alt_q         <= '0;
			ax_q          <= '0;
			ay_q          <= '0;
			az_q          <= '0;
			sq_idx_q      <= '0;
			prod_s1       <= '0;
			acc_q         <= '0;
			arm_idx_q     <= '0;
			rd_addr_q     <= '0;
			issue_k_q     <= '0;
			rd_pend_s1    <= 1'b0;
			best_q        <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_alarm_q   <= 1'b0;
			rsp_cause_q   <= fda_pkg::CAUSE_NONE;
			rsp_low_g_q   <= 1'b0;
			rsp_armed_q   <= 1'b0;
			rsp_drop_q    <= '0;
		end else begin
			if (rsp.ready && state_q != S_EMIT) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						now_q <= req.now_ms;
						alt_q <= req.altitude_cm;
						ax_q  <= req.accel_x;
						ay_q  <= req.accel_y;
						az_q  <= req.accel_z;
						unique case (req.operation)
							fda_pkg::OP_ARM: begin
								state_q      <= S_ARM;
								arm_idx_q    <= '0;
								slot_q       <= '0;
								armed_q      <= 1'b1;
								alarm_q      <= 1'b0;
								cause_q      <= fda_pkg::CAUSE_NONE;
								low_g_seen_q <= 1'b0;
								drop_q       <= '0;
							end
							fda_pkg::OP_ACCEL: begin
								if (active) begin
									state_q  <= S_SQ;
									sq_idx_q <= '0;
									prod_s1  <= '0;
									acc_q    <= '0;
								end else begin
									state_q <= S_EMIT;
								end
							end
							fda_pkg::OP_ALT: begin
								if (active) begin
									state_q    <= S_WALK;
									rd_addr_q  <= (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
									issue_k_q  <= CNT_W'(1);
									rd_pend_s1 <= 1'b0;
									best_q     <= '0;
								end else begin
									state_q <= S_EMIT;
								end
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_ARM: begin
					if (arm_idx_q == LAST_SLOT) begin
						state_q <= S_EMIT;
					end else begin
						arm_idx_q <= arm_idx_q + 1'b1;
					end
				end
				S_SQ: begin
					prod_s1 <= sq_prod;
					acc_q   <= acc_q + prod_s1;
					if (sq_idx_q == 2'd2) begin
						state_q <= S_SUM;
					end else begin
						sq_idx_q <= sq_idx_q + 1'b1;
					end
				end
				S_SUM: begin
					if (mag_sq < low_g_thr_sq_q) begin
						if (low_g_seen_q) begin
							if (low_g_age > {16'b0, low_g_hold_q}) begin
								alarm_q <= 1'b1;
								cause_q <= fda_pkg::CAUSE_LOW_G;
							end
						end else begin
							low_g_seen_q  <= 1'b1;
							low_g_start_q <= now_q;
						end
					end else begin
						low_g_seen_q <= 1'b0;
					end
					state_q <= S_EMIT;
				end
				S_WALK: begin
					best_q <= best_n;
					if (hit) begin
						alarm_q <= 1'b1;
						cause_q <= fda_pkg::CAUSE_DESCENT;
					end
					if (walk_done) begin
						rd_pend_s1 <= 1'b0;
						drop_q     <= drop_sat;
						slot_q     <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
						state_q    <= S_EMIT;
					end else begin
						// the read of rd_addr_q goes out this cycle
						rd_pend_s1 <= 1'b1;
						rd_addr_q  <= (rd_addr_q == '0) ? LAST_SLOT : rd_addr_q - 1'b1;
						issue_k_q  <= issue_k_q + 1'b1;
					end
				end
				S_EMIT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_alarm_q <= alarm_q;
						rsp_cause_q <= cause_q;
						rsp_low_g_q <= low_g_seen_q;
						rsp_armed_q <= armed_q;
						rsp_drop_q  <= drop_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.alarm        = rsp_alarm_q;
	assign rsp.alarm_cause  = rsp_cause_q;
	assign rsp.low_g_active = rsp_low_g_q;
	assign rsp.is_armed     = rsp_armed_q;
	assign rsp.drop_cm      = rsp_drop_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while another is in work");

	a_cause_matches_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_alarm_q == (rsp_cause_q != fda_pkg::CAUSE_NONE)))
		else $error("alarm flag and cause disagree");

	a_alarm_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(alarm_q && !(accept && req.operation == fda_pkg::OP_ARM)) |=> alarm_q)
		else $error("alarm dropped without arm");

	a_drop_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !rsp_drop_q[31])
		else $error("negative drop reported");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int RING_DEPTH = 16;
	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [31:0]        now_ms;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic signed [31:0] alt;
	} sample_t;

	typedef struct packed {
		logic               alarm;
		logic [1:0]         cause;
		logic               low_g;
		logic               armed;
		logic signed [31:0] drop;
	} status_t;

	class alarm_scoreboard;
		logic [31:0]        low_g_thr_sq;
		logic [15:0]        low_g_hold;
		logic [16:0]        descent_thr;
		logic [15:0]        descent_win;
		logic signed [31:0] alt_ring [RING_DEPTH];
		logic [31:0]        stamp_ring [RING_DEPTH];
		int unsigned        slot;
		bit                 armed;
		bit                 alarm;
		bit                 low_g_seen;
		fda_pkg::cause_t    cause;
		logic [31:0]        low_g_start;
		logic signed [31:0] last_drop;
		status_t            status_q [$];
		int                 errors;

		function new();
			low_g_thr_sq = fda_pkg::RST_LOW_G_THR_SQ;
			low_g_hold = fda_pkg::RST_LOW_G_HOLD;
			descent_thr = fda_pkg::RST_DESCENT_THR;
			descent_win = fda_pkg::RST_DESCENT_WIN;
			foreach (alt_ring[i]) begin
				alt_ring[i] = '0;
				stamp_ring[i] = '0;
			end
			slot = 0;
			armed = 0;
			alarm = 0;
			low_g_seen = 0;
			cause = fda_pkg::CAUSE_NONE;
			low_g_start = '0;
			last_drop = '0;
			errors = 0;
		endfunction

		function void set_reg(fda_pkg::cfg_idx_t idx, logic [31:0] val);
			case (idx)
				fda_pkg::CFG_LOW_G_THR_SQ: low_g_thr_sq = val;
				fda_pkg::CFG_LOW_G_HOLD:   low_g_hold = val[15:0];
				fda_pkg::CFG_DESCENT_THR:  descent_thr = val[16:0];
				fda_pkg::CFG_DESCENT_WIN:  descent_win = val[15:0];
			endcase
		endfunction

		function void take_request(sample_t s);
			int xs, ys, zs;
			logic [33:0] mag2;
			logic [31:0] age;
			logic signed [32:0] drop, best;
			int unsigned cur, older;
			status_t st;
			xs = s.ax;
			ys = s.ay;
			zs = s.az;
			if (s.op == fda_pkg::OP_ARM) begin
				foreach (alt_ring[i]) begin
					alt_ring[i] = s.alt;
					stamp_ring[i] = s.now_ms - fda_pkg::STALE_OFFSET;
				end
				slot = 0;
				armed = 1;
				alarm = 0;
				cause = fda_pkg::CAUSE_NONE;
				low_g_seen = 0;
				last_drop = '0;
			end else if (armed && !alarm) begin
				if (s.op == fda_pkg::OP_ACCEL) begin
					mag2 = 34'(xs * xs) + 34'(ys * ys) + 34'(zs * zs);
					if (mag2 < {2'b0, low_g_thr_sq}) begin
						if (low_g_seen) begin
							age = s.now_ms - low_g_start;
							if (age > {16'b0, low_g_hold}) begin
								alarm = 1;
								cause = fda_pkg::CAUSE_LOW_G;
							end
						end else begin
							low_g_seen = 1;
							low_g_start = s.now_ms;
						end
					end else begin
						low_g_seen = 0;
					end
				end else if (s.op == fda_pkg::OP_ALT) begin
					cur = slot;
					best = '0;
					alt_ring[cur] = s.alt;
					stamp_ring[cur] = s.now_ms;
					for (int k = 1; k < RING_DEPTH; k++) begin
						older = (cur + RING_DEPTH - k) % RING_DEPTH;
						age = s.now_ms - stamp_ring[older];
						if (age >= {16'b0, descent_win})
							break;
						drop = {alt_ring[older][31], alt_ring[older]} - {s.alt[31], s.alt};
						if (drop > best)
							best = drop;
						if (drop >= $signed({16'b0, descent_thr})) begin
							alarm = 1;
							cause = fda_pkg::CAUSE_DESCENT;
							break;
						end
					end
					last_drop = (best > fda_pkg::DROP_SAT) ? 32'sh7FFF_FFFF : best[31:0];
					slot = (cur + 1) % RING_DEPTH;
				end
			end
			st.alarm = alarm;
			st.cause = cause;
			st.low_g = low_g_seen;
			st.armed = armed;
			st.drop = last_drop;
			status_q.push_back(st);
		endfunction

		task report(string what);
			$display("%0t: status mismatch: %s", $time, what);
			errors++;
		endtask

		task check_status(status_t got);
			status_t want;
			if (status_q.size() == 0) begin
				report("result with no request outstanding");
			end else begin
				want = status_q.pop_front();
				if (got.alarm !== want.alarm)
					report($sformatf("alarm got %0b want %0b", got.alarm, want.alarm));
				if (got.cause !== want.cause)
					report($sformatf("alarm_cause got %0d want %0d", got.cause, want.cause));
				if (got.low_g !== want.low_g)
					report($sformatf("low_g_active got %0b want %0b", got.low_g, want.low_g));
				if (got.armed !== want.armed)
					report($sformatf("is_armed got %0b want %0b", got.armed, want.armed));
				if (got.drop !== want.drop)
					report($sformatf("drop_cm got %0d want %0d", got.drop, want.drop));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [fda_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fda_pkg::CFG_DATA_W-1:0] cfg_data;
	bit idle_on;
	int stall_cycles;
	alarm_scoreboard sb;

	fda_req_if req_ch ();
	fda_rsp_if rsp_ch ();

	freefall_descent_alarm #(
		.RING_DEPTH(RING_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always #10 clk = ~clk;

	// called right after a rising edge; returns at the edge that took the request
	task automatic drive_req(logic [1:0] op, logic [31:0] now_ms, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] az, logic signed [31:0] alt);
		sample_t s;
		s = '{op: op, now_ms: now_ms, ax: ax, ay: ay, az: az, alt: alt};
		while (idle_on && $urandom_range(0, 99) < 24) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.now_ms <= now_ms;
		req_ch.accel_x <= ax;
		req_ch.accel_y <= ay;
		req_ch.accel_z <= az;
		req_ch.altitude_cm <= alt;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.take_request(s);
	endtask

	// caller drops cfg_we after the last write
	task automatic write_reg(fda_pkg::cfg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// block must be idle before its registers change
	task automatic set_phase(logic [31:0] thr_sq, logic [15:0] hold, logic [16:0] dthr,
			logic [15:0] win);
		req_ch.valid <= 1'b0;
		while (sb.status_q.size() != 0)
			@(posedge clk);
		write_reg(fda_pkg::CFG_LOW_G_THR_SQ, thr_sq);
		write_reg(fda_pkg::CFG_LOW_G_HOLD, {16'b0, hold});
		write_reg(fda_pkg::CFG_DESCENT_THR, {15'b0, dthr});
		write_reg(fda_pkg::CFG_DESCENT_WIN, {16'b0, win});
		cfg_we <= 1'b0;
	endtask

	// arm, then sample bursts with drifting altitude and near-threshold accel
	task automatic fly(int n_items);
		logic [31:0] t_ms;
		logic signed [31:0] alt;
		logic signed [15:0] ax, ay, az;
		logic [1:0] op;
		int left, pick, lim, drift;
		left = n_items;
		lim = 0;
		while (lim < 32767 && 3 * longint'(lim + 1) * (lim + 1) < longint'(sb.low_g_thr_sq))
			lim++;
		drift = int'(sb.descent_thr / 3) + 1;
		t_ms = $urandom;
		alt = $urandom;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			if (!sb.armed || (sb.alarm && pick < 85) || pick < 3)
				op = fda_pkg::OP_ARM;
			else if (pick < 7)
				op = 2'($urandom_range(0, 3));
			else if (pick < 53)
				op = fda_pkg::OP_ACCEL;
			else
				op = fda_pkg::OP_ALT;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: t_ms += $urandom_range(0, sb.descent_win / 8 + 1);
				6, 7, 8: t_ms += $urandom_range(0, sb.low_g_hold / 2 + 2);
				default: t_ms += $urandom;
			endcase
			if ($urandom_range(0, 9) < 7) begin
				ax = 16'(int'($urandom_range(0, 2 * lim)) - lim);
				ay = 16'(int'($urandom_range(0, 2 * lim)) - lim);
				az = 16'(int'($urandom_range(0, 2 * lim)) - lim);
			end else begin
				ax = 16'($urandom);
				ay = 16'($urandom);
				az = 16'($urandom);
			end
			case ($urandom_range(0, 9))
				0: alt = $urandom;
				1, 2: alt = alt + int'($urandom_range(0, 4)) - 2;
				default: alt = alt - int'($urandom_range(0, drift)) + int'($urandom_range(0, drift / 2));
			endcase
			left--;
			drive_req(op, t_ms, ax, ay, az, alt);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_status('{alarm: rsp_ch.alarm, cause: rsp_ch.alarm_cause,
				low_g: rsp_ch.low_g_active, armed: rsp_ch.is_armed, drop: rsp_ch.drop_cm});
		rsp_ch.ready <= !(idle_on && $urandom_range(0, 99) < 24);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		stall_cycles = 0;
		req_ch.valid = 1'b0;
		req_ch.operation = '0;
		req_ch.now_ms = '0;
		req_ch.accel_x = '0;
		req_ch.accel_y = '0;
		req_ch.accel_z = '0;
		req_ch.altitude_cm = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values; nothing acts before arm
		drive_req(OP_SPARE, 32'hFFFF_FFFF, -16'sd1, -16'sd1, -16'sd1, -32'sd1);
		drive_req(fda_pkg::OP_ACCEL, 32'd0, 16'sd0, 16'sd0, 16'sd0, 32'sd0);
		drive_req(fda_pkg::OP_ALT, 32'd5, 16'sd0, 16'sd0, 16'sd0, -32'sd1);
		drive_req(fda_pkg::OP_ARM, 32'h7FFF_FF00, 16'sd0, 16'sd0, 16'sd0, 32'sd0);
		drive_req(fda_pkg::OP_ACCEL, 32'h7FFF_FF00, -16'sd32768, -16'sd32768, -16'sd32768,
			32'sd0);
		drive_req(fda_pkg::OP_ACCEL, 32'h7FFF_FF01, 16'sd0, 16'sd0, 16'sd0, 32'sd0);
		// age equal to hold does not fire
		drive_req(fda_pkg::OP_ACCEL, 32'h7FFF_FF01 + 32'd1000, 16'sd0, 16'sd0, 16'sd0, 32'sd0);
		drive_req(OP_SPARE, 32'h7FFF_FF01 + 32'd1000, 16'sd0, 16'sd0, 16'sd0, 32'sd0);
		drive_req(fda_pkg::OP_ACCEL, 32'h7FFF_FF01 + 32'd1001, 16'sd32767, 16'sd0, 16'sd0,
			32'sd0);
		drive_req(fda_pkg::OP_ACCEL, 32'h7FFF_FF01 + 32'd1002, 16'sd4000, 16'sd1000,
			-16'sd1000, 32'sd0);
		drive_req(fda_pkg::OP_ACCEL, 32'h7FFF_FF01 + 32'd2003, 16'sd1, -16'sd1, 16'sd1, 32'sd0);
		drive_req(fda_pkg::OP_ALT, 32'h7FFF_FF01 + 32'd2004, 16'sd0, 16'sd0, 16'sd0,
			-32'sd5000);
		// timestamp wrap and saturated drop
		drive_req(fda_pkg::OP_ARM, 32'hFFFF_FF00, 16'sd0, 16'sd0, 16'sd0, 32'sh7FFF_FFFF);
		drive_req(fda_pkg::OP_ALT, 32'hFFFF_FF80, 16'sd0, 16'sd0, 16'sd0, 32'sh7FFF_FFFF);
		drive_req(fda_pkg::OP_ALT, 32'h0000_0010, 16'sd0, 16'sd0, 16'sd0, 32'sh8000_0000);
		drive_req(fda_pkg::OP_ARM, 32'd1000, 16'sd0, 16'sd0, 16'sd0, 32'sh8000_0000);
		drive_req(fda_pkg::OP_ALT, 32'd1000, 16'sd0, 16'sd0, 16'sd0, 32'sd500);
		drive_req(fda_pkg::OP_ALT, 32'd1999, 16'sd0, 16'sd0, 16'sd0, -32'sd499);
		// entry exactly one window old is stale
		drive_req(fda_pkg::OP_ALT, 32'd2000, 16'sd0, 16'sd0, 16'sd0, -32'sd500);
		// drop exactly at threshold, found two slots back
		drive_req(fda_pkg::OP_ALT, 32'd2002, 16'sd0, 16'sd0, 16'sd0, -32'sd1499);
		drive_req(fda_pkg::OP_ACCEL, 32'd2003, 16'sd0, 16'sd0, 16'sd0, 32'sd0);

		set_phase($urandom_range(32'h0010_0000, 32'h4000_0000), 16'($urandom_range(0, 3000)),
			17'($urandom_range(1, 5000)), 16'($urandom_range(1, 3000)));
		fly(100);
		idle_on = 1'b0;
		set_phase(32'd0, 16'd0, 17'd1, 16'd65535);
		fly(60);
		idle_on = 1'b1;
		set_phase(32'd3221225472, 16'd65535, 17'd100000, 16'd1);
		fly(60);
		// threshold and window of zero, every sample low g
		set_phase(32'hFFFF_FFFF, 16'($urandom_range(0, 65535)), 17'd0, 16'd0);
		fly(60);
		set_phase($urandom, 16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)),
			16'($urandom_range(0, 65535)));
		fly(120);

		req_ch.valid <= 1'b0;
		while (sb.status_q.size() != 0)
			@(posedge clk);
		repeat (RING_DEPTH + 8) @(posedge clk);
		if (sb.errors == 0 && sb.status_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
src/fda_pkg.sv
src/fda_req_if.sv
src/fda_rsp_if.sv
src/freefall_descent_alarm.sv
sim/tb_top.sv
